### rtl/dehl_pkg.sv
// ----------------------------------------------------------------------------
// dehl_pkg
// Shared types and constants for the deduplicating event history log.
// ----------------------------------------------------------------------------
package dehl_pkg;

  localparam int DEPTH = 12;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_RESET  = 2'd1,
    MODE_PLAIN  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_INSERTED  = 3'd0,
    ACT_DUPLICATE = 3'd1,
    ACT_RESET     = 3'd2,
    ACT_NOT_FOUND = 3'd3,
    ACT_CLEARED   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_MARK,
    OP_CLEAR
  } store_op_t;

  typedef struct packed {
    store_op_t        op;
    logic [IDX_W-1:0] mark_idx;
    logic [15:0]      key;
    logic [15:0]      num;
    logic [39:0]      tstamp;
  } store_cmd_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  entry_count;
    logic [3:0]  matched_slot;
    logic        oldest_dropped;
  } result_t;

endpackage

### rtl/dehl_store.sv
// ----------------------------------------------------------------------------
// dehl_store
// Entry registers, newest at slot 0, with a shifting insert, a reset mark,
// a clear and one indexed read port for the scan.
// ----------------------------------------------------------------------------
module dehl_store (
  input  logic                      clk,
  input  logic                      rst,
  input  dehl_pkg::store_cmd_t      cmd,
  input  logic [dehl_pkg::IDX_W-1:0] rd_idx,
  output logic [15:0]               rd_key,
  output logic                      rd_is_reset,
  output logic [dehl_pkg::CNT_W-1:0] count
);
  import dehl_pkg::*;

  logic [15:0] entry_key      [DEPTH];
  logic [15:0] entry_number   [DEPTH];
  logic [39:0] entry_time     [DEPTH];
  logic        entry_is_reset [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR:  count <= '0;
        OP_INSERT: begin
          if (count != CNT_W'(DEPTH)) begin
            count <= count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Entries beyond the count are shifted too; they are never read.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        for (int i = 1; i < DEPTH; i++) begin
          entry_key[i]      <= entry_key[i-1];
          entry_number[i]   <= entry_number[i-1];
          entry_time[i]     <= entry_time[i-1];
          entry_is_reset[i] <= entry_is_reset[i-1];
        end
        entry_key[0]      <= cmd.key;
        entry_number[0]   <= cmd.num;
        entry_time[0]     <= cmd.tstamp;
        entry_is_reset[0] <= 1'b0;
      end
      OP_MARK: entry_is_reset[cmd.mark_idx] <= 1'b1;
      default: ;
    endcase
  end

  assign rd_key      = entry_key[rd_idx];
  assign rd_is_reset = entry_is_reset[rd_idx];

endmodule

### rtl/dehl_ctrl.sv
// ----------------------------------------------------------------------------
// dehl_ctrl
// Sequencer and shared key comparator: for single and reset requests, walks the
// valid entries oldest first, one per cycle, until the first active match, then issues the store update and the result.
// ----------------------------------------------------------------------------
module dehl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [15:0]                msg_key,
  input  logic [15:0]                error_number,
  input  logic [39:0]                timestamp,
  input  logic                       out_free,
  input  logic [dehl_pkg::CNT_W-1:0] count,
  input  logic [15:0]                rd_key,
  input  logic                       rd_is_reset,
  output logic [dehl_pkg::IDX_W-1:0] rd_idx,
  output dehl_pkg::store_cmd_t       cmd,
  output logic                       res_valid,
  output dehl_pkg::result_t          res
);
  import dehl_pkg::*;

  state_t           state, state_next;
  mode_t            mode_in;
  mode_t            mode_r;
  logic [15:0]      key_r;
  logic [15:0]      num_r;
  logic [39:0]      tstamp_r;
  logic [IDX_W-1:0] idx;
  logic             hit;
  logic             scan_hit;
  logic             do_scan;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] count_after;
  logic             full;
  logic [CNT_W+3:0] count_wide;
  logic [IDX_W+3:0] slot_wide;

  assign mode_in    = mode_t'(mode);
  assign scan_hit   = (rd_key == key_r) && !rd_is_reset;
  assign do_scan    = ((mode_in == MODE_SINGLE) || (mode_in == MODE_RESET)) &&
                      (count != '0);
  assign count_m1   = count - CNT_W'(1);
  assign full       = (count == CNT_W'(DEPTH));
  assign rd_idx     = idx;
  assign slot_wide  = {4'b0, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      mode_r   <= mode_in;
      key_r    <= msg_key;
      num_r    <= error_number;
      tstamp_r <= timestamp;
      idx      <= count_m1[IDX_W-1:0];
      hit      <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (scan_hit) begin
        hit <= 1'b1;
      end else if (idx != '0) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    cmd.op         = OP_NONE;
    cmd.mark_idx   = idx;
    cmd.key        = key_r;
    cmd.num        = num_r;
    cmd.tstamp     = tstamp_r;
    count_after    = count;
    res.action     = ACT_INSERTED;
    res.matched_slot   = 4'd0;
    res.oldest_dropped = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = do_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (scan_hit || idx == '0) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
        unique case (mode_r)
          MODE_CLEAR: begin
            cmd.op      = OP_CLEAR;
            res.action  = ACT_CLEARED;
            count_after = '0;
          end
          MODE_RESET: begin
            if (hit) begin
              cmd.op           = OP_MARK;
              res.action       = ACT_RESET;
              res.matched_slot = slot_wide[3:0];
            end else begin
              res.action = ACT_NOT_FOUND;
            end
          end
          MODE_SINGLE: begin
            if (hit) begin
              res.action       = ACT_DUPLICATE;
              res.matched_slot = slot_wide[3:0];
            end else begin
              cmd.op             = OP_INSERT;
              res.oldest_dropped = full;
              count_after        = full ? count : count + CNT_W'(1);
            end
          end
          MODE_PLAIN: begin
            cmd.op             = OP_INSERT;
            res.oldest_dropped = full;
            count_after        = full ? count : count + CNT_W'(1);
          end
          default: ;
        endcase
        // hold the store until the result can be written out
        if (!out_free) begin
          cmd.op = OP_NONE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    count_wide      = {4'b0, count_after};
    res.entry_count = count_wide[3:0];
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CNT_W'(idx) < count))
    else $error("scan index outside valid entries");

  a_cmd_only_on_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> (state == ST_APPLY && out_free && res_valid))
    else $error("store update without a result");

  a_hit_mode: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && hit) |-> (mode_r == MODE_SINGLE || mode_r == MODE_RESET))
    else $error("match flagged for a mode that does not search");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (state == ST_IDLE))
    else $error("sequencer not idle after result");
`endif

endmodule

### rtl/dedup_event_history_log.sv
// ----------------------------------------------------------------------------
// dedup_event_history_log
// Newest-first error history with duplicate suppression and entry reset.
// ----------------------------------------------------------------------------
// One request is taken at a time. Plain and clear requests, and single and
// reset requests on an empty log, go from acceptance straight to the apply
// state; other single and reset requests first pass the scan state, where
// the key comparator examines entries oldest first, one per cycle, until
// the first active match (at most the valid entry count). A waiting
// result sits in the output register, so the next request is accepted while
// it is still stalled; a new result is only held back while that register is occupied.
module dedup_event_history_log (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] msg_key,
  input  logic [15:0] error_number,
  input  logic [39:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [3:0]  entry_count,
  output logic [3:0]  matched_slot,
  output logic        oldest_dropped
);
  import dehl_pkg::*;

  store_cmd_t       cmd;
  result_t          res;
  logic             res_valid;
  logic             out_free;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      rd_key;
  logic             rd_is_reset;
  logic [CNT_W-1:0] count;

  assign out_free = !out_valid || !out_stall;

  dehl_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .rd_key      (rd_key),
    .rd_is_reset (rd_is_reset),
    .count       (count)
  );

  dehl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .msg_key      (msg_key),
    .error_number (error_number),
    .timestamp    (timestamp),
    .out_free     (out_free),
    .count        (count),
    .rd_key       (rd_key),
    .rd_is_reset  (rd_is_reset),
    .rd_idx       (rd_idx),
    .cmd          (cmd),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      action         <= res.action;
      entry_count    <= res.entry_count;
      matched_slot   <= res.matched_slot;
      oldest_dropped <= res.oldest_dropped;
    end
  end

endmodule
